// File: hw/rtl/frd_pkg.sv
// Shared types and constants for the receive deframer.
package frd_pkg;

  // Frame opening and closing bytes (high nibbles for the channel messages)
  localparam logic [3:0] HI_ANALOG      = 4'hE;
  localparam logic [3:0] HI_DIGITAL     = 4'h9;
  localparam logic [3:0] HI_REP_ANALOG  = 4'hC;
  localparam logic [3:0] HI_REP_DIGITAL = 4'hD;
  localparam logic [7:0] MSG_VERSION    = 8'hF9;
  localparam logic [7:0] SYX_START      = 8'hF0;
  localparam logic [7:0] SYX_END        = 8'hF7;

  // Sysex command bytes
  localparam logic [7:0] SYX_FIRMWARE   = 8'h79;
  localparam logic [7:0] SYX_CAPABILITY = 8'h6C;
  localparam logic [7:0] SYX_ANAMAP     = 8'h6A;
  localparam logic [7:0] SYX_PINSTATE   = 8'h6E;

  // Event kinds
  localparam logic [2:0] KIND_ANALOG     = 3'd0;
  localparam logic [2:0] KIND_DIGITAL    = 3'd1;
  localparam logic [2:0] KIND_FIRMWARE   = 3'd2;
  localparam logic [2:0] KIND_CAPABILITY = 3'd3;
  localparam logic [2:0] KIND_ANAMAP     = 3'd4;
  localparam logic [2:0] KIND_PINSTATE   = 3'd5;
  localparam logic [2:0] KIND_SYSEX      = 3'd6;
  localparam logic [2:0] KIND_UNKNOWN    = 3'd7;

  // Register indexes (paddr[2])
  localparam logic REG_ANALOG_LIMIT = 1'b0;
  localparam logic REG_PIN_LIMIT    = 1'b1;

  localparam logic [4:0] ANALOG_LIMIT_RST = 5'd16;
  localparam logic [7:0] PIN_LIMIT_RST    = 8'd128;

  typedef struct packed {
    logic [4:0] analog_channel_limit;
    logic [7:0] digital_pin_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  channel_or_port;
    logic [13:0] value_14;
    logic [7:0]  pin_valid_mask;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [7:0]  sysex_command;
    logic [7:0]  first_byte;
    logic [12:0] frame_bytes;
    logic        channel_overflow;
  } evt_t;

endpackage

// File: hw/rtl/frd_cfg_regs.sv
// APB-style configuration registers for the receive deframer.
module frd_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output frd_pkg::cfg_t     cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.analog_channel_limit <= frd_pkg::ANALOG_LIMIT_RST;
      cfg.digital_pin_limit    <= frd_pkg::PIN_LIMIT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        frd_pkg::REG_ANALOG_LIMIT: cfg.analog_channel_limit <= pwdata[4:0];
        frd_pkg::REG_PIN_LIMIT:    cfg.digital_pin_limit    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      frd_pkg::REG_ANALOG_LIMIT: prdata = {27'd0, cfg.analog_channel_limit};
      frd_pkg::REG_PIN_LIMIT:    prdata = {24'd0, cfg.digital_pin_limit};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// File: hw/rtl/frd_in_stage.sv
// Input register for received bytes.
module frd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_q
);

  assign rx_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx_ready) begin
      byte_valid <= rx_valid;
    end
  end

  // Payload: load on every accepted beat
  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      byte_q <= rx_byte;
    end
  end

endmodule

// File: hw/rtl/frd_framer.sv
// Frame tracking state, header store, event decode and result register.
module frd_framer #(
  parameter int MAX_FRAME = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  frd_pkg::cfg_t  cfg,
  input  logic           byte_valid,
  input  logic [7:0]     byte_q,
  output logic           advance,
  output logic           event_valid,
  input  logic           event_ready,
  output frd_pkg::evt_t  evt
);

  localparam int CW = $clog2(MAX_FRAME + 1);

  logic [CW-1:0] expected_length;
  logic [CW-1:0] received_count;
  logic [7:0]    header_bytes [4];

  logic [CW-1:0] exp_b, cnt_b, cnt_inc;
  logic [CW-1:0] expected_length_next, received_count_next;
  logic [3:0]    hi;
  logic          take, hdr_wr, emit;
  logic [7:0]    hdr_eff [4];
  logic [7:0]    first;
  logic [3:0]    port;
  logic [6:0]    pin;
  frd_pkg::evt_t evt_next;

  assign advance = byte_valid && (!event_valid || event_ready);
  assign hi      = byte_q[7:4];

  // Frame length from the opening byte
  always_comb begin
    exp_b = expected_length;
    cnt_b = received_count;
    if (hi == frd_pkg::HI_ANALOG || hi == frd_pkg::HI_DIGITAL ||
        byte_q == frd_pkg::MSG_VERSION) begin
      exp_b = CW'(3);
      cnt_b = '0;
    end else if (hi == frd_pkg::HI_REP_ANALOG || hi == frd_pkg::HI_REP_DIGITAL) begin
      exp_b = CW'(2);
      cnt_b = '0;
    end else if (byte_q == frd_pkg::SYX_START) begin
      exp_b = CW'(MAX_FRAME);
      cnt_b = '0;
    end else if (byte_q == frd_pkg::SYX_END) begin
      exp_b = received_count + CW'(1);
    end else if (byte_q[7]) begin
      exp_b = CW'(1);
      cnt_b = '0;
    end
  end

  assign take    = cnt_b <= exp_b;
  assign hdr_wr  = take && (cnt_b < CW'(4));
  assign cnt_inc = cnt_b + CW'(1);
  assign emit    = take && (cnt_inc == exp_b);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hdr_eff[i] = (hdr_wr && cnt_b[1:0] == 2'(i)) ? byte_q : header_bytes[i];
    end
  end

  always_comb begin
    if (!take || emit) begin
      expected_length_next = '0;
      received_count_next  = '0;
    end else begin
      expected_length_next = exp_b;
      received_count_next  = cnt_inc;
    end
  end

  // Judge the completed frame by its first byte
  assign first = hdr_eff[0];
  assign port  = first[3:0];

  always_comb begin
    evt_next = '0;
    evt_next.event_kind  = frd_pkg::KIND_UNKNOWN;
    evt_next.first_byte  = first;
    evt_next.frame_bytes = 13'(cnt_inc);
    pin = '0;
    if (first[7:4] == frd_pkg::HI_ANALOG && cnt_inc == CW'(3)) begin
      evt_next.event_kind       = frd_pkg::KIND_ANALOG;
      evt_next.channel_or_port  = port;
      evt_next.value_14         = {hdr_eff[2][6:0], 7'd0} | {6'd0, hdr_eff[1]};
      evt_next.channel_overflow = {1'b0, port} >= cfg.analog_channel_limit;
    end else if (first[7:4] == frd_pkg::HI_DIGITAL && cnt_inc == CW'(3)) begin
      evt_next.event_kind      = frd_pkg::KIND_DIGITAL;
      evt_next.channel_or_port = port;
      evt_next.value_14        = {hdr_eff[2][6:0], 7'd0} | {6'd0, hdr_eff[1]};
      for (int i = 0; i < 8; i++) begin
        pin = {port, 3'(i)};
        evt_next.pin_valid_mask[i] = {1'b0, pin} < cfg.digital_pin_limit;
      end
    end else if (first == frd_pkg::SYX_START && byte_q == frd_pkg::SYX_END) begin
      evt_next.sysex_command = hdr_eff[1];
      if (hdr_eff[1] == frd_pkg::SYX_FIRMWARE) begin
        evt_next.event_kind    = frd_pkg::KIND_FIRMWARE;
        evt_next.version_major = hdr_eff[2];
        evt_next.version_minor = hdr_eff[3];
      end else if (hdr_eff[1] == frd_pkg::SYX_CAPABILITY) begin
        evt_next.event_kind = frd_pkg::KIND_CAPABILITY;
      end else if (hdr_eff[1] == frd_pkg::SYX_ANAMAP) begin
        evt_next.event_kind = frd_pkg::KIND_ANAMAP;
      end else if (hdr_eff[1] == frd_pkg::SYX_PINSTATE && cnt_inc >= CW'(6)) begin
        evt_next.event_kind = frd_pkg::KIND_PINSTATE;
      end else begin
        evt_next.event_kind = frd_pkg::KIND_SYSEX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= '0;
      received_count  <= '0;
      event_valid     <= 1'b0;
    end else if (advance) begin
      expected_length <= expected_length_next;
      received_count  <= received_count_next;
      event_valid     <= emit;
    end else if (event_ready) begin
      event_valid <= 1'b0;
    end
  end

  // Header store and result payload need no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      if (hdr_wr) begin
        header_bytes[cnt_b[1:0]] <= byte_q;
      end
      if (emit) begin
        evt <= evt_next;
      end
    end
  end

endmodule

// File: hw/rtl/firmata_receive_deframer_core.sv
// Top level of the receive deframer: config port, input stage and framer.
//
// Receive deframer for a MIDI-style serial control protocol. Each rx beat
// carries one received byte; the block groups bytes into frames (3-byte
// analog, digital and version messages, 2-byte report messages, sysex
// frames closed by 0xF7 or at MAX_FRAME bytes, 1-byte other commands) and
// sends one event beat per completed frame, none for bytes that leave a
// frame open. Throughput is one byte per clock while the event side does
// not stall: the byte sits in an input register, then the frame counters,
// the four-entry header store and the event decode update together and
// load the event register. rx_ready stays high while the event register
// is empty or being drained, so a pending event does not block the next
// byte by more than the stall on the event side.
// Analog channels at or above analog_channel_limit (register 0, address 0)
// are flagged in channel_overflow; pins at or above digital_pin_limit
// (register 1, address 4) are cleared in pin_valid_mask. Write the limits
// only while no frame is in flight.
module firmata_receive_deframer_core #(
  parameter int MAX_FRAME = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Received bytes
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  // Frame events
  output logic        event_valid,
  input  logic        event_ready,
  output logic [2:0]  event_kind,
  output logic [3:0]  channel_or_port,
  output logic [13:0] value_14,
  output logic [7:0]  pin_valid_mask,
  output logic [7:0]  version_major,
  output logic [7:0]  version_minor,
  output logic [7:0]  sysex_command,
  output logic [7:0]  first_byte,
  output logic [12:0] frame_bytes,
  output logic        channel_overflow
);

  frd_pkg::cfg_t cfg;
  frd_pkg::evt_t evt;
  logic          advance;
  logic          byte_valid;
  logic [7:0]    byte_q;

  frd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Register the accepted byte ahead of the framer
  frd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  // Advance frame state and load the event register
  frd_framer #(
    .MAX_FRAME (MAX_FRAME)
  ) u_framer (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .byte_valid  (byte_valid),
    .byte_q      (byte_q),
    .advance     (advance),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .evt         (evt)
  );

  assign event_kind       = evt.event_kind;
  assign channel_or_port  = evt.channel_or_port;
  assign value_14         = evt.value_14;
  assign pin_valid_mask   = evt.pin_valid_mask;
  assign version_major    = evt.version_major;
  assign version_minor    = evt.version_minor;
  assign sysex_command    = evt.sysex_command;
  assign first_byte       = evt.first_byte;
  assign frame_bytes      = evt.frame_bytes;
  assign channel_overflow = evt.channel_overflow;

endmodule

// File: hw/rtl/frd_checker.sv
// Port-level checks for the receive deframer, bound to the top level.
module frd_checker (
  input logic        clk,
  input logic        rst,
  input logic        event_valid,
  input logic        event_ready,
  input logic [2:0]  event_kind,
  input logic [7:0]  first_byte,
  input logic [12:0] frame_bytes,
  input logic        channel_overflow
);

  // A stalled event beat holds its payload
  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_ready |=> event_valid && $stable(event_kind) &&
      $stable(first_byte) && $stable(frame_bytes))
    else $error("event beat changed while stalled");

  // Analog and digital events are always three-byte frames
  a_short_len: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind == frd_pkg::KIND_ANALOG ||
      event_kind == frd_pkg::KIND_DIGITAL) |-> frame_bytes == 13'd3)
    else $error("analog or digital event with wrong frame length");

  // Sysex kinds come only from frames that open with the sysex start byte
  a_sysex_first: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind == frd_pkg::KIND_FIRMWARE ||
      event_kind == frd_pkg::KIND_CAPABILITY || event_kind == frd_pkg::KIND_ANAMAP ||
      event_kind == frd_pkg::KIND_PINSTATE || event_kind == frd_pkg::KIND_SYSEX)
      |-> first_byte == frd_pkg::SYX_START && frame_bytes >= 13'd2)
    else $error("sysex event without sysex start byte");

  // Overflow flag is only raised on analog events
  a_ovf_analog: assert property (@(posedge clk) disable iff (rst)
    event_valid && channel_overflow |-> event_kind == frd_pkg::KIND_ANALOG)
    else $error("channel overflow on a non-analog event");

  // No event beat right after reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !event_valid)
    else $error("event valid right after reset");

endmodule

bind firmata_receive_deframer_core frd_checker u_frd_checker (.*);

// File: test/firmata_receive_deframer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the receive deframer core: serial bytes in, frame events out.
module tb;

  localparam int FRAME_MAX     = 4096;
  localparam int SETTLE_CYCLES = 8;     // byte-to-event pipeline plus margin
  localparam int QUIET_LIMIT   = 5000;  // cycles with no beat anywhere before giving up
  localparam int PHASE_BYTES   = 70;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        rx_valid = 1'b0;
  logic        rx_ready;
  logic [7:0]  rx_byte = '0;
  logic        event_valid;
  logic        event_ready = 1'b0;
  logic [2:0]  event_kind;
  logic [3:0]  channel_or_port;
  logic [13:0] value_14;
  logic [7:0]  pin_valid_mask;
  logic [7:0]  version_major;
  logic [7:0]  version_minor;
  logic [7:0]  sysex_command;
  logic [7:0]  first_byte;
  logic [12:0] frame_bytes;
  logic        channel_overflow;

  firmata_receive_deframer_core #(.MAX_FRAME(FRAME_MAX)) uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the open frame, the four-byte header store and the limits.
  int         open_len = 0;
  int         open_cnt = 0;
  logic [7:0] hdr_mem [4];
  logic [3:0] hdr_seen = '0;           // header entries written since reset
  logic [4:0] lim_chan = frd_pkg::ANALOG_LIMIT_RST;
  logic [7:0] lim_pin = frd_pkg::PIN_LIMIT_RST;

  frd_pkg::evt_t frames_due [$];       // events owed by the block, oldest first
  int   errors = 0;
  int   bytes_in = 0;
  bit   no_gaps = 1'b0;
  int   quiet = 0;

  function automatic frd_pkg::evt_t mk_evt(logic [2:0] kind, logic [3:0] chan,
                                           logic [13:0] val, logic [7:0] mask,
                                           logic [7:0] maj, logic [7:0] mnr,
                                           logic [7:0] cmd, logic [7:0] first,
                                           logic [12:0] nbytes, logic ovf);
    return {kind, chan, val, mask, maj, mnr, cmd, first, nbytes, ovf};
  endfunction

  // Advance the framer by one byte; report the event it completes, if any.
  function automatic void deframe_byte(input logic [7:0] b, output bit fired,
                                       output frd_pkg::evt_t ev);
    logic [2:0] kind;
    logic [3:0] chan;
    int         val;
    logic [7:0] mask, maj, mnr, cmd, first;
    logic       ovf;
    fired = 1'b0;
    ev = '0;
    // Status bytes open a new frame; the end byte only fixes the length
    if (b[7:4] == frd_pkg::HI_ANALOG || b[7:4] == frd_pkg::HI_DIGITAL ||
        b == frd_pkg::MSG_VERSION) begin
      open_len = 3;
      open_cnt = 0;
    end else if (b[7:4] == frd_pkg::HI_REP_ANALOG || b[7:4] == frd_pkg::HI_REP_DIGITAL) begin
      open_len = 2;
      open_cnt = 0;
    end else if (b == frd_pkg::SYX_START) begin
      open_len = FRAME_MAX;
      open_cnt = 0;
    end else if (b == frd_pkg::SYX_END) begin
      open_len = open_cnt + 1;
    end else if (b[7]) begin
      open_len = 1;
      open_cnt = 0;
    end
    if (open_cnt > open_len) begin
      // second stray data byte: drop it and clear the frame
      open_cnt = 0;
      open_len = 0;
    end else begin
      if (open_cnt < 4) begin
        hdr_mem[open_cnt] = b;
        hdr_seen[open_cnt] = 1'b1;
      end
      open_cnt++;
      if (open_cnt == open_len) begin
        first = hdr_mem[0];
        kind = frd_pkg::KIND_UNKNOWN;
        chan = '0;
        val = 0;
        mask = '0;
        maj = '0;
        mnr = '0;
        cmd = '0;
        ovf = 1'b0;
        if ((first[7:4] == frd_pkg::HI_ANALOG || first[7:4] == frd_pkg::HI_DIGITAL) &&
            open_cnt == 3) begin
          chan = first[3:0];
          val = (int'(hdr_mem[1]) | (int'(hdr_mem[2]) << 7)) & 'h3FFF;
          if (first[7:4] == frd_pkg::HI_ANALOG) begin
            kind = frd_pkg::KIND_ANALOG;
            ovf = ({1'b0, chan} >= lim_chan);
          end else begin
            kind = frd_pkg::KIND_DIGITAL;
            for (int i = 0; i < 8; i++) mask[i] = (int'(chan) * 8 + i < int'(lim_pin));
          end
        end else if (first == frd_pkg::SYX_START && b == frd_pkg::SYX_END) begin
          cmd = hdr_mem[1];
          if (cmd == frd_pkg::SYX_FIRMWARE) begin
            kind = frd_pkg::KIND_FIRMWARE;
            maj = hdr_mem[2];
            mnr = hdr_mem[3];
          end else if (cmd == frd_pkg::SYX_CAPABILITY) begin
            kind = frd_pkg::KIND_CAPABILITY;
          end else if (cmd == frd_pkg::SYX_ANAMAP) begin
            kind = frd_pkg::KIND_ANAMAP;
          end else if (cmd == frd_pkg::SYX_PINSTATE && open_cnt >= 6) begin
            kind = frd_pkg::KIND_PINSTATE;
          end else begin
            kind = frd_pkg::KIND_SYSEX;
          end
        end
        ev = mk_evt(kind, chan, 14'(val), mask, maj, mnr, cmd, first, 13'(open_cnt), ovf);
        fired = 1'b1;
        open_cnt = 0;
        open_len = 0;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Data byte with the extremes weighted up.
  function automatic logic [7:0] data7();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'h7F;
    return 8'($urandom_range(0, 127));
  endfunction

  // Drive one rx beat, wait for it to be taken, then book its event.
  task automatic push_byte(input logic [7:0] b, input bit given,
                           input frd_pkg::evt_t given_ev);
    frd_pkg::evt_t ev;
    bit   fired;
    int   g;
    // An end byte here would close a short firmware report whose minor byte
    // was never stored; send a data byte instead and keep the sysex open.
    if (b == frd_pkg::SYX_END && open_cnt == 2 && hdr_mem[0] == frd_pkg::SYX_START &&
        hdr_mem[1] == frd_pkg::SYX_FIRMWARE && !hdr_seen[3])
      b = 8'h00;
    g = idle_len();
    if (g > 0) begin
      rx_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (rx_ready !== 1'b1);
    bytes_in++;
    deframe_byte(b, fired, ev);
    if (fired) frames_due.push_back(given ? given_ev : ev);
  endtask

  // One random frame: mostly well formed with random content, some noise.
  task automatic send_frame();
    int         r, n;
    logic [7:0] cmd;
    if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      push_byte({(r < 15) ? frd_pkg::HI_ANALOG : frd_pkg::HI_DIGITAL,
                 4'($urandom_range(0, 15))}, 1'b0, '0);
      push_byte(data7(), 1'b0, '0);
      push_byte(data7(), 1'b0, '0);
    end else if (r < 36) begin
      push_byte(frd_pkg::MSG_VERSION, 1'b0, '0);
      push_byte(data7(), 1'b0, '0);
      push_byte(data7(), 1'b0, '0);
    end else if (r < 46) begin
      push_byte({(r < 41) ? frd_pkg::HI_REP_ANALOG : frd_pkg::HI_REP_DIGITAL,
                 4'($urandom_range(0, 15))}, 1'b0, '0);
      push_byte(data7(), 1'b0, '0);
    end else if (r < 74) begin
      case ($urandom_range(0, 4))
        0: cmd = frd_pkg::SYX_FIRMWARE;
        1: cmd = frd_pkg::SYX_CAPABILITY;
        2: cmd = frd_pkg::SYX_ANAMAP;
        3: cmd = frd_pkg::SYX_PINSTATE;
        default: cmd = data7();
      endcase
      push_byte(frd_pkg::SYX_START, 1'b0, '0);
      push_byte(cmd, 1'b0, '0);
      n = $urandom_range(0, 7);
      repeat (n) push_byte(data7(), 1'b0, '0);
      push_byte(frd_pkg::SYX_END, 1'b0, '0);
    end else if (r < 84) begin
      // lone status byte: a one-byte command or an opener cut short
      push_byte(8'($urandom_range(128, 255)), 1'b0, '0);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) push_byte(8'($urandom()), 1'b0, '0);
    end
  endtask

  // Drop valid, wait for every owed event, then let the pipeline empty.
  task automatic drain();
    rx_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a limit register, then read it back.
  task automatic set_limit(input logic reg_sel, input logic [31:0] v);
    logic [31:0] keep;
    keep = (reg_sel == frd_pkg::REG_ANALOG_LIMIT) ? 32'h1F : 32'hFF;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == frd_pkg::REG_ANALOG_LIMIT) lim_chan = v[4:0];
    else lim_pin = v[7:0];
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    check_field("prdata", v & keep, prdata & keep);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Compare every event beat with the oldest owed event, field by field.
  always @(posedge clk) begin : event_check
    frd_pkg::evt_t want;
    if (!rst && event_valid === 1'b1 && event_ready) begin
      if (frames_due.size() == 0) begin
        $error("event beat with no frame pending (first_byte 0x%0h)", first_byte);
        errors++;
      end else begin
        want = frames_due.pop_front();
        check_field("event_kind", want.event_kind, event_kind);
        check_field("channel_or_port", want.channel_or_port, channel_or_port);
        check_field("value_14", want.value_14, value_14);
        check_field("pin_valid_mask", want.pin_valid_mask, pin_valid_mask);
        check_field("version_major", want.version_major, version_major);
        check_field("version_minor", want.version_minor, version_minor);
        check_field("sysex_command", want.sysex_command, sysex_command);
        check_field("first_byte", want.first_byte, first_byte);
        check_field("frame_bytes", want.frame_bytes, frame_bytes);
        check_field("channel_overflow", want.channel_overflow, channel_overflow);
      end
    end
  end

  // Event side: stall at random, with occasional long runs of steady ready.
  initial begin : event_sink
    int n;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        event_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      event_ready <= 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      repeat (n) @(posedge clk);
    end
  end

  // Watchdog: give up when no beat moves on any port for too long.
  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ready) || (event_valid && event_ready) || psel) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("firmata_receive_deframer_core regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    logic [7:0]    dir_bytes [$];
    frd_pkg::evt_t dir_given [int];
    logic [4:0]    chan_lim;
    logic [7:0]    pin_lim;
    int            mark;
    for (int i = 0; i < 4; i++) hdr_mem[i] = '0;

    // Directed bytes, checked with the reset limits (16 channels, 128 pins).
    dir_bytes = '{8'hE5, 8'h7F, 8'h7F,              // analog, all value bits set
                  8'h9F, 8'h00, 8'h00,              // digital, top port, value zero
                  8'hF9, 8'h01, 8'h02,              // version message
                  8'hD0, 8'h7F,                     // report message
                  8'hF0, 8'h79, 8'h02, 8'h05, 8'hF7, // firmware report
                  8'hF0, 8'h79, 8'hF7,              // short firmware report
                  8'hF0, 8'h6C, 8'hF7,              // capability response
                  8'hF0, 8'h6A, 8'hF7,              // analog map response
                  8'h00, 8'h01, 8'h00, 8'hF7};      // stray, dropped, stray, end byte
    dir_given[2]  = mk_evt(frd_pkg::KIND_ANALOG, 4'd5, 14'h3FFF, '0, '0, '0, '0,
                           8'hE5, 13'd3, 1'b0);
    dir_given[5]  = mk_evt(frd_pkg::KIND_DIGITAL, 4'd15, '0, 8'hFF, '0, '0, '0,
                           8'h9F, 13'd3, 1'b0);
    dir_given[8]  = mk_evt(frd_pkg::KIND_UNKNOWN, '0, '0, '0, '0, '0, '0,
                           8'hF9, 13'd3, 1'b0);
    dir_given[10] = mk_evt(frd_pkg::KIND_UNKNOWN, '0, '0, '0, '0, '0, '0,
                           8'hD0, 13'd2, 1'b0);
    dir_given[15] = mk_evt(frd_pkg::KIND_FIRMWARE, '0, '0, '0, 8'h02, 8'h05,
                           frd_pkg::SYX_FIRMWARE, frd_pkg::SYX_START, 13'd5, 1'b0);
    // the end byte closes the open stray byte as a two-byte frame
    dir_given[28] = mk_evt(frd_pkg::KIND_UNKNOWN, '0, '0, '0, '0, '0, '0,
                           8'h00, 13'd2, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < dir_bytes.size(); i++)
      push_byte(dir_bytes[i], dir_given.exists(i), dir_given.exists(i) ? dir_given[i] : '0);
    drain();

    // Random phases, each under its own limits; extremes first.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin chan_lim = 5'd0;  pin_lim = 8'd0;   end
        1: begin chan_lim = 5'd16; pin_lim = 8'd128; end
        2: begin chan_lim = 5'd15; pin_lim = 8'd8;   end
        3: begin chan_lim = 5'd1;  pin_lim = 8'd127; end
        default: begin
          chan_lim = 5'($urandom_range(0, 16));
          pin_lim = 8'($urandom_range(0, 128));
        end
      endcase
      set_limit(frd_pkg::REG_ANALOG_LIMIT, 32'(chan_lim));
      set_limit(frd_pkg::REG_PIN_LIMIT, 32'(pin_lim));
      mark = bytes_in;
      while (bytes_in - mark < PHASE_BYTES) send_frame();
      // close whatever is open so the next limits apply to fresh frames only
      push_byte(8'hFF, 1'b0, '0);
      drain();
    end

    if (errors == 0) begin
      $display("firmata_receive_deframer_core regression: pass");
    end else begin
      $display("firmata_receive_deframer_core regression: fail");
    end
    $finish;
  end

endmodule
